/* hw/rtl/pap_pkg.sv */
// shared types, constants and the angle wrap helper for the pairwise angle panner
`timescale 1ns / 1ps
`default_nettype none

package pap_pkg;

    localparam int ANG_W = 13;
    localparam int CH_W  = 3;
    localparam int DIST_W = 14;
    localparam int WGT_W = 17;

    localparam logic [ANG_W-1:0]  FULL_CIRCLE = 13'd5760;
    localparam logic [DIST_W-1:0] FULL_DIST   = 14'd5760;
    localparam logic [WGT_W-1:0]  ONE_Q16     = 17'h10000;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_ADD   = 2'd1;
    localparam logic [1:0] ACT_PAN   = 2'd2;

    typedef struct packed {
        logic [ANG_W-1:0] angle;
        logic [CH_W-1:0]  chan;
    } t_entry;

    typedef struct packed {
        logic             ins;
        logic [ANG_W-1:0] angle;
        logic [CH_W-1:0]  chan;
    } t_cell_ctl;

    // signed 16-bit angle reduced into 0..5759 by four conditional subtracts
    function automatic logic [ANG_W-1:0] wrap_angle(input logic [15:0] a);
        logic [17:0] t;
        t = {{2{a[15]}}, a} + 18'd34560;
        if (t >= 18'd46080) t = t - 18'd46080;
        if (t >= 18'd23040) t = t - 18'd23040;
        if (t >= 18'd11520) t = t - 18'd11520;
        if (t >= 18'd5760)  t = t - 18'd5760;
        return t[ANG_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/pap_cell.sv */
// one speaker slot of the sorted table, shifts right on an insert
`timescale 1ns / 1ps
`default_nettype none

module pap_cell
    import pap_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_cell_ctl i_ctl,
    input  wire logic      i_occupied,
    input  wire logic      i_tail,
    input  wire t_entry    i_left,
    input  wire logic      i_left_gt,
    output t_entry         o_entry,
    output logic           o_gt,
    output logic           o_ge
);

    t_entry r_entry;
    t_entry n_entry;

    assign o_entry = r_entry;
    assign o_gt    = i_occupied && (r_entry.angle > i_ctl.angle);
    assign o_ge    = i_occupied && (r_entry.angle >= i_ctl.angle);

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (i_left_gt) begin
                n_entry = i_left;
            end else if (o_gt || i_tail) begin
                n_entry.angle = i_ctl.angle;
                n_entry.chan  = i_ctl.chan;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

/* hw/rtl/pap_div.sv */
// serial restoring divider, rounded Q16 quotient, one bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module pap_div
    import pap_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIST_W-1:0] i_num,
    input  wire logic [DIST_W-1:0] i_den,
    output logic [WGT_W-1:0]       o_quot,
    output logic                   o_done
);

    localparam int STEPS = WGT_W;

    logic [31:0]       w_dividend;
    logic [DIST_W:0]   r_rem;
    logic [WGT_W-1:0]  r_bits;
    logic [WGT_W-1:0]  r_q;
    logic [DIST_W-1:0] r_den;
    logic [4:0]        r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIST_W+1:0] w_trial;
    logic              w_fit;

    // num * 65536 + den / 2, the rounding term folded in up front
    assign w_dividend = {2'b00, i_num, 16'h0000} + {19'd0, i_den[DIST_W-1:1]};
    assign w_trial    = {r_rem, r_bits[WGT_W-1]};
    assign w_fit      = w_trial >= {2'b00, r_den};
    assign o_quot     = r_q;
    assign o_done     = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= w_dividend[31:WGT_W];
            r_bits <= w_dividend[WGT_W-1:0];
            r_den  <= i_den;
            r_q    <= '0;
        end else if (r_busy) begin
            r_rem  <= w_fit ? (DIST_W+1)'(w_trial - {2'b00, r_den}) : w_trial[DIST_W:0];
            r_bits <= {r_bits[WGT_W-2:0], 1'b0};
            r_q    <= {r_q[WGT_W-2:0], w_fit};
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/pairwise_angle_panner_core.sv */
// pairwise angle panner: sorted speaker table, weight dividers and channel output
// Usage of the block:
// Input channel (i_valid / o_ready) carries one item: an action with its angle,
// speaker output, sample and block marker. Clear empties the table, add inserts
// a speaker in angle order (dropped when the table is full), pan splits the
// sample between the two speakers that bracket the source angle.
// A pan gives output_count result items (clamped to 1..MAX_OUTPUTS) on the
// output channel (o_valid / i_ready), channel 0 upward, last set on the final
// one. Clear and add give none. The config channel (i_cfg_valid / o_cfg_ready)
// writes output_count and is always ready; the user must write it only while the
// block is idle, which the block does not enforce. Clear and add return to
// idle from the execute state. A pan with two or more speakers steps through
// distance, divider start, divider wait, multiply and output; the serial weight
// divide, one quotient bit per cycle, is skipped when the distances sum to zero
// and with fewer speakers. Results follow one per cycle while the receiver takes
// them. The next item is accepted as soon as the last result sits in the output
// register, so a stalled receiver holds only that register.
// Reset clears the table count and sets output_count to 2; the speaker slots
// themselves are not cleared and are only read below the count.
`timescale 1ns / 1ps
`default_nettype none

module pairwise_angle_panner_core
    import pap_pkg::*;
#(
    parameter int MAX_SPEAKERS = 8,
    parameter int MAX_OUTPUTS  = 8,
    parameter int SAMPLE_WIDTH = 24
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [1:0]                     i_action,
    input  wire logic signed [15:0]             i_angle,
    input  wire logic [2:0]                     i_speaker_output,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  wire logic                           i_block_last,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [2:0]                          o_out_channel,
    output logic signed [SAMPLE_WIDTH-1:0]      o_out_value,
    output logic                                o_last,
    output logic                                o_block_end,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [3:0]                     i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_SPEAKERS + 1);
    localparam int OIW   = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
    localparam int SW    = SAMPLE_WIDTH;
    localparam int PW    = SAMPLE_WIDTH + WGT_W + 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_DIST   = 3'd2;
    localparam logic [2:0] S_DSTART = 3'd3;
    localparam logic [2:0] S_DWAIT  = 3'd4;
    localparam logic [2:0] S_MUL    = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [2:0]             r_state;
    logic [CNT_W-1:0]       r_count;
    logic [3:0]             r_ocount;
    logic [1:0]             r_action;
    logic [ANG_W-1:0]       r_ang;
    logic [CH_W-1:0]        r_spk;
    logic signed [SW-1:0]   r_sample;
    logic                   r_blk;
    logic [OIW-1:0]         r_nout_m1;
    logic [OIW-1:0]         r_idx;
    t_entry                 r_left;
    t_entry                 r_right;
    logic                   r_wrap;
    logic                   r_use1;
    logic                   r_use2;
    logic [DIST_W-1:0]      r_a1;
    logic [DIST_W-1:0]      r_a2;
    logic [DIST_W-1:0]      r_sum;
    logic [WGT_W-1:0]       r_w1;
    logic [WGT_W-1:0]       r_w2;
    logic signed [SW-1:0]   r_v1;
    logic signed [SW-1:0]   r_v2;
    logic                   r_ov;
    logic [2:0]             r_out_ch;
    logic signed [SW-1:0]   r_out_val;
    logic                   r_out_last;
    logic                   r_out_blk;

    t_cell_ctl              w_ctl;
    t_entry                 w_entry [MAX_SPEAKERS];
    logic [MAX_SPEAKERS-1:0] w_gt;
    logic [MAX_SPEAKERS-1:0] w_ge;
    logic [MAX_SPEAKERS-1:0] w_occ;
    logic [MAX_SPEAKERS-1:0] w_tail;
    logic [MAX_SPEAKERS-1:0] w_first;
    logic [MAX_SPEAKERS-1:0] w_is_end;
    logic [MAX_SPEAKERS-1:0] w_sel_l;
    logic [MAX_SPEAKERS-1:0] w_sel_r;
    logic                   w_wrap;
    t_entry                 w_left;
    t_entry                 w_right;
    logic                   w_full;
    logic [5:0]             w_oc;
    logic [OIW-1:0]         w_nout_m1;
    logic [DIST_W-1:0]      w_a1;
    logic [DIST_W-1:0]      w_a2;
    logic [DIST_W-1:0]      w_ang;
    logic [DIST_W-1:0]      w_al;
    logic [DIST_W-1:0]      w_ar;
    logic                   w_div_start;
    logic [WGT_W-1:0]       w_q1;
    logic [WGT_W-1:0]       w_q2;
    logic                   w_done1;
    logic                   w_done2;
    logic signed [PW-1:0]   w_p1;
    logic signed [PW-1:0]   w_p2;
    logic                   w_out_free;
    logic signed [SW-1:0]   w_val;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid       = r_ov;
    assign o_out_channel = r_out_ch;
    assign o_out_value   = r_out_val;
    assign o_last        = r_out_last;
    assign o_block_end   = r_out_blk;

    assign w_full = (r_count == CNT_W'(MAX_SPEAKERS));

    assign w_ctl.ins   = (r_state == S_EXEC) && (r_action == ACT_ADD) && !w_full;
    assign w_ctl.angle = r_ang;
    assign w_ctl.chan  = r_spk;

    // speaker table as a row of cells, each but the first fed by its left neighbor
    for (genvar g = 0; g < MAX_SPEAKERS; g++) begin : g_cell
        assign w_occ[g]    = CNT_W'(g) < r_count;
        assign w_tail[g]   = CNT_W'(g) == r_count;
        assign w_is_end[g] = CNT_W'(g + 1) == r_count;
        if (g == 0) begin : g_head
            pap_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_occupied (w_occ[g]),
                .i_tail     (w_tail[g]),
                .i_left     (w_entry[g]),
                .i_left_gt  (1'b0),
                .o_entry    (w_entry[g]),
                .o_gt       (w_gt[g]),
                .o_ge       (w_ge[g])
            );
            assign w_first[g] = w_ge[g];
        end else begin : g_body
            pap_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_occupied (w_occ[g]),
                .i_tail     (w_tail[g]),
                .i_left     (w_entry[g-1]),
                .i_left_gt  (w_gt[g-1]),
                .o_entry    (w_entry[g]),
                .o_gt       (w_gt[g]),
                .o_ge       (w_ge[g])
            );
            assign w_first[g] = w_ge[g] && !w_ge[g-1];
        end
    end

    // bracketing pair: right is the first slot at or above the angle, else slot 0
    assign w_wrap = (w_ge == '0) || w_first[0];

    always_comb begin
        w_sel_l = '0;
        w_sel_r = '0;
        if (w_wrap) begin
            w_sel_r[0] = 1'b1;
            w_sel_l    = w_is_end;
        end else begin
            w_sel_r = w_first;
            for (int k = 0; k < MAX_SPEAKERS - 1; k++) begin
                w_sel_l[k] = w_first[k+1];
            end
        end
        w_left  = '0;
        w_right = '0;
        for (int k = 0; k < MAX_SPEAKERS; k++) begin
            if (w_sel_l[k]) w_left  = w_left  | w_entry[k];
            if (w_sel_r[k]) w_right = w_right | w_entry[k];
        end
    end

    // angular distances to the left and right speakers
    assign w_ang = {1'b0, r_ang};
    assign w_al  = {1'b0, r_left.angle};
    assign w_ar  = {1'b0, r_right.angle};

    always_comb begin
        if (r_wrap) begin
            if (w_ang >= w_al) begin
                w_a1 = w_ang - w_al;
                w_a2 = FULL_DIST - w_ang + w_ar;
            end else begin
                w_a1 = FULL_DIST - w_al + w_ang;
                w_a2 = (w_ar >= w_ang) ? (w_ar - w_ang) : (w_ang - w_ar);
            end
        end else begin
            w_a1 = (w_al >= w_ang) ? (w_al - w_ang) : (w_ang - w_al);
            w_a2 = (w_ar >= w_ang) ? (w_ar - w_ang) : (w_ang - w_ar);
        end
    end

    assign w_div_start = (r_state == S_DSTART) && (r_sum != '0);

    pap_div u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_a2),
        .i_den   (r_sum),
        .o_quot  (w_q1),
        .o_done  (w_done1)
    );

    pap_div u_div2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_a1),
        .i_den   (r_sum),
        .o_quot  (w_q2),
        .o_done  (w_done2)
    );

    // round half up: floor((s * w + 0x8000) / 0x10000)
    assign w_p1 = r_sample * $signed({1'b0, r_w1}) + PW'(32768);
    assign w_p2 = r_sample * $signed({1'b0, r_w2}) + PW'(32768);

    // channel count clamped to 1..MAX_OUTPUTS
    assign w_oc = {2'b00, r_ocount};
    always_comb begin
        if (w_oc == 6'd0) begin
            w_nout_m1 = '0;
        end else if (w_oc > 6'(MAX_OUTPUTS)) begin
            w_nout_m1 = OIW'(MAX_OUTPUTS - 1);
        end else begin
            w_nout_m1 = OIW'(w_oc - 6'd1);
        end
    end

    always_comb begin
        if (r_use1 && (32'(r_idx) == 32'(r_left.chan))) begin
            w_val = r_v1;
        end else if (r_use2 && (32'(r_idx) == 32'(r_right.chan))) begin
            w_val = r_v2;
        end else begin
            w_val = '0;
        end
    end

    assign w_out_free = !r_ov || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ocount <= 4'd2;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_ocount <= i_cfg_data;
            end
            // a new result loads over a taken one in the same cycle
            if ((r_state == S_OUT) && w_out_free) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (r_action == ACT_CLEAR) begin
                        r_count <= '0;
                        r_state <= S_IDLE;
                    end else if (r_action == ACT_ADD) begin
                        if (!w_full) r_count <= r_count + CNT_W'(1);
                        r_state <= S_IDLE;
                    end else if (r_action == ACT_PAN) begin
                        r_state <= S_DIST;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_DIST: begin
                    r_state <= r_use2 ? S_DSTART : S_MUL;
                end
                S_DSTART: begin
                    r_state <= (r_sum == '0) ? S_MUL : S_DWAIT;
                end
                S_DWAIT: begin
                    if (w_done1) r_state <= S_MUL;
                end
                S_MUL: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free && (r_idx == r_nout_m1)) r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_valid) begin
            r_action <= i_action;
            r_ang    <= wrap_angle(i_angle);
            r_spk    <= i_speaker_output;
            r_sample <= i_sample;
            r_blk    <= i_block_last;
        end
        if (r_state == S_EXEC) begin
            r_left    <= w_left;
            r_right   <= w_right;
            r_wrap    <= w_wrap;
            r_use1    <= r_count != '0;
            r_use2    <= r_count > CNT_W'(1);
            r_nout_m1 <= w_nout_m1;
            r_w1      <= ONE_Q16;
            r_w2      <= '0;
        end
        if (r_state == S_DIST) begin
            r_a1  <= w_a1;
            r_a2  <= w_a2;
            r_sum <= w_a1 + w_a2;
        end
        if ((r_state == S_DSTART) && (r_sum == '0)) begin
            r_w1 <= '0;
            r_w2 <= ONE_Q16;
        end
        if ((r_state == S_DWAIT) && w_done1) begin
            r_w1 <= w_q1;
            r_w2 <= w_q2;
        end
        if (r_state == S_MUL) begin
            r_v1  <= w_p1[SW+15:16];
            r_v2  <= w_p2[SW+15:16];
            r_idx <= '0;
        end
        if ((r_state == S_OUT) && w_out_free) begin
            r_out_ch   <= 3'(r_idx);
            r_out_val  <= w_val;
            r_out_last <= (r_idx == r_nout_m1);
            r_out_blk  <= r_blk;
            r_idx      <= r_idx + OIW'(1);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SPEAKERS))
        else $error("speaker count past table depth");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_idx <= r_nout_m1))
        else $error("result index past channel count");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_EXEC))
        else $error("accepted item not executed");

    a_angle_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> (r_ang < FULL_CIRCLE))
        else $error("angle not reduced below full circle");

    a_div_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done1 == w_done2)
        else $error("weight dividers out of step");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// self-checking bench for the pairwise angle panner: table ops, pans and output count settings
`timescale 1ns / 1ps

module tb_top;
    import pap_pkg::*;

    localparam int SW       = 24;
    localparam int MAX_SPK  = 8;
    localparam int MAX_OUT  = 8;
    localparam int CIRCLE   = 5760;
    localparam int SETTLE   = 40;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]    action;
        logic [15:0]   angle;
        logic [2:0]    spk;
        logic [SW-1:0] sample;
        logic          blk;
    } t_pan_item;

    typedef struct {
        logic [2:0]    chan;
        logic [SW-1:0] value;
        logic          last;
        logic          blk;
    } t_chan_result;

    logic          i_clk;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          o_ready;
    logic [1:0]    i_action = '0;
    logic [15:0]   i_angle = '0;
    logic [2:0]    i_speaker_output = '0;
    logic [SW-1:0] i_sample = '0;
    logic          i_block_last = 1'b0;
    logic          o_valid;
    logic          i_ready = 1'b0;
    logic [2:0]    o_out_channel;
    logic [SW-1:0] o_out_value;
    logic          o_last;
    logic          o_block_end;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [3:0]    i_cfg_data = '0;

    pairwise_angle_panner_core #(
        .MAX_SPEAKERS(MAX_SPK),
        .MAX_OUTPUTS (MAX_OUT),
        .SAMPLE_WIDTH(SW)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_action        (i_action),
        .i_angle         (i_angle),
        .i_speaker_output(i_speaker_output),
        .i_sample        (i_sample),
        .i_block_last    (i_block_last),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_channel   (o_out_channel),
        .o_out_value     (o_out_value),
        .o_last          (o_last),
        .o_block_end     (o_block_end),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    // mirror of the block state
    logic [ANG_W-1:0] spk_angle [MAX_SPK];
    logic [2:0]       spk_chan  [MAX_SPK];
    int               spk_count = 0;
    logic [3:0]       outputs_reg = 4'd2;

    t_pan_item    panner_items_q [$];
    t_chan_result channel_results_q [$];
    t_pan_item    drv_item;
    int           error_count = 0;

    bit item_taken   = 1'b0;
    bit result_taken = 1'b0;
    int tx_wait = 0;
    int tx_max  = 7;
    int rx_wait = 0;
    int rx_max  = 7;
    int hold_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [ANG_W-1:0] fold_angle(input logic [15:0] raw);
        int a;
        a = int'($signed(raw));
        a = a % CIRCLE;
        if (a < 0) a += CIRCLE;
        return a[ANG_W-1:0];
    endfunction

    function automatic longint gain_q16(input longint num, input longint sum);
        return (num * 65536 + sum / 2) / sum;
    endfunction

    // rounds half up, floor division for negative products
    function automatic logic [SW-1:0] apply_gain(input logic [SW-1:0] raw, input longint w);
        longint s;
        longint p;
        longint q;
        s = longint'($signed(raw));
        p = s * w + 32768;
        if (p >= 0) q = p / 65536;
        else q = -((-p + 65535) / 65536);
        return q[SW-1:0];
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic predict_channels(input t_pan_item it);
        logic [ANG_W-1:0] ang;
        int n;
        int nout;
        int idx;
        int left;
        int right;
        bit found;
        bit use1;
        bit use2;
        int ch1;
        int ch2;
        longint la;
        longint lr;
        longint a;
        longint a1;
        longint a2;
        longint sum;
        longint w1;
        longint w2;
        t_chan_result r;
        ang = fold_angle(it.angle);
        n = spk_count;
        use1 = 1'b0;
        use2 = 1'b0;
        ch1 = 0;
        ch2 = 0;
        w1 = 0;
        w2 = 0;
        case (it.action)
            ACT_CLEAR: begin
                spk_count = 0;
            end
            ACT_ADD: begin
                if (n < MAX_SPK) begin
                    // equal angles keep insertion order
                    idx = n;
                    while (idx > 0 && spk_angle[idx-1] > ang) begin
                        spk_angle[idx] = spk_angle[idx-1];
                        spk_chan[idx]  = spk_chan[idx-1];
                        idx--;
                    end
                    spk_angle[idx] = ang;
                    spk_chan[idx]  = it.spk;
                    spk_count = n + 1;
                end
            end
            ACT_PAN: begin
                if (n == 1) begin
                    ch1 = int'(spk_chan[0]);
                    w1 = 65536;
                    use1 = 1'b1;
                end else if (n >= 2) begin
                    found = 1'b0;
                    right = 0;
                    for (idx = 0; idx < n; idx++) begin
                        if (!found && spk_angle[idx] >= ang) begin
                            right = idx;
                            found = 1'b1;
                        end
                    end
                    if (!found) begin
                        right = 0;
                        left = n - 1;
                    end else begin
                        left = (right == 0) ? n - 1 : right - 1;
                    end
                    la = longint'(spk_angle[left]);
                    lr = longint'(spk_angle[right]);
                    a = longint'(ang);
                    if (right == 0) begin
                        // pair straddles the wrap point
                        if (a >= la) begin
                            a1 = a - la;
                            a2 = (CIRCLE - a) + lr;
                        end else begin
                            a1 = (CIRCLE - la) + a;
                            a2 = (lr >= a) ? lr - a : a - lr;
                        end
                    end else begin
                        a1 = (la >= a) ? la - a : a - la;
                        a2 = (lr >= a) ? lr - a : a - lr;
                    end
                    sum = a1 + a2;
                    if (sum == 0) begin
                        w1 = 0;
                        w2 = 65536;
                    end else begin
                        w1 = gain_q16(a2, sum);
                        w2 = gain_q16(a1, sum);
                    end
                    ch1 = int'(spk_chan[left]);
                    ch2 = int'(spk_chan[right]);
                    use1 = 1'b1;
                    use2 = 1'b1;
                end
                nout = int'(outputs_reg);
                if (nout == 0) nout = 1;
                if (nout > MAX_OUT) nout = MAX_OUT;
                for (idx = 0; idx < nout; idx++) begin
                    r.chan = idx[2:0];
                    r.value = '0;
                    if (use1 && idx == ch1) r.value = apply_gain(it.sample, w1);
                    else if (use2 && idx == ch2) r.value = apply_gain(it.sample, w2);
                    r.last = (idx + 1 == nout);
                    r.blk = it.blk;
                    channel_results_q.push_back(r);
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_channel();
        t_chan_result want;
        if (channel_results_q.size() == 0) begin
            report_error($sformatf("unexpected result ch %0d value %0d",
                                   o_out_channel, $signed(o_out_value)));
        end else begin
            want = channel_results_q.pop_front();
            if (o_out_channel !== want.chan || o_out_value !== want.value ||
                o_last !== want.last || o_block_end !== want.blk) begin
                report_error($sformatf(
                    "got ch %0d val %0d last %b blk %b, want ch %0d val %0d last %b blk %b",
                    o_out_channel, $signed(o_out_value), o_last, o_block_end,
                    want.chan, $signed(want.value), want.last, want.blk));
            end
        end
    endtask

    // monitor: predict on input accept, check on output accept
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                predict_channels(drv_item);
                item_taken = 1'b1;
            end
            if (o_valid && i_ready) begin
                check_channel();
                result_taken = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) outputs_reg = i_cfg_data;
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_cycles > 0) hold_cycles = hold_cycles - 1;
    end

    // input driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || item_taken)) begin
            if (tx_wait > 0) begin
                tx_wait--;
                i_valid <= 1'b0;
            end else if (panner_items_q.size() > 0) begin
                drv_item = panner_items_q.pop_front();
                i_action         <= drv_item.action;
                i_angle          <= drv_item.angle;
                i_speaker_output <= drv_item.spk;
                i_sample         <= drv_item.sample;
                i_block_last     <= drv_item.blk;
                i_valid          <= 1'b1;
                tx_wait = $urandom_range(0, tx_max);
            end else begin
                i_valid <= 1'b0;
            end
        end
        item_taken = 1'b0;
    end

    // output receiver
    always @(negedge i_clk) begin
        if (result_taken) begin
            rx_wait = $urandom_range(0, rx_max);
            result_taken = 1'b0;
        end
        if (hold_cycles > 0) begin
            i_ready <= 1'b0;
        end else if (rx_wait > 0) begin
            i_ready <= 1'b0;
            rx_wait--;
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic push_item(input logic [1:0] action, input logic [15:0] angle,
                             input logic [2:0] spk, input logic [SW-1:0] sample,
                             input logic blk);
        t_pan_item it;
        it.action = action;
        it.angle  = angle;
        it.spk    = spk;
        it.sample = sample;
        it.blk    = blk;
        panner_items_q.push_back(it);
    endtask

    task automatic wait_drained();
        while (!(panner_items_q.size() == 0 && !i_valid && channel_results_q.size() == 0))
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_outputs(input logic [3:0] val);
        @(negedge i_clk);
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_angle();
        int sel;
        sel = $urandom_range(0, 3);
        if (sel < 2) return 16'($urandom_range(0, 65535));
        else if (sel == 2) return 16'($urandom_range(0, CIRCLE - 1));
        else return 16'($urandom_range(0, 15) * 360);   // lands on shared angles
    endfunction

    function automatic logic [SW-1:0] pick_sample();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return 24'h7FFFFF;
        else if (sel == 1) return 24'h800000;
        else return 24'($urandom() & 32'h00FF_FFFF);
    endfunction

    // usually clear, fill with a few speakers, then pan; occasional noise items
    task automatic random_scene(inout int counted);
        int k;
        int npan;
        int j;
        if ($urandom_range(0, 9) != 0) begin
            push_item(ACT_CLEAR, 16'($urandom_range(0, 65535)), 3'($urandom_range(0, 7)),
                      pick_sample(), 1'($urandom_range(0, 1)));
            counted++;
        end
        k = $urandom_range(0, 10);
        for (j = 0; j < k; j++) begin
            push_item(ACT_ADD, pick_angle(), 3'($urandom_range(0, 7)), pick_sample(),
                      1'($urandom_range(0, 1)));
            counted++;
        end
        npan = $urandom_range(1, 6);
        for (j = 0; j < npan; j++) begin
            if ($urandom_range(0, 9) == 0)
                push_item(ACT_UNUSED, 16'($urandom_range(0, 65535)),
                          3'($urandom_range(0, 7)), pick_sample(),
                          1'($urandom_range(0, 1)));
            push_item(ACT_PAN, pick_angle(), 3'($urandom_range(0, 7)), pick_sample(),
                      1'($urandom_range(0, 1)));
            counted++;
        end
    endtask

    initial begin
        int phase;
        int counted;
        int j;
        logic [3:0] setting;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, output count at its reset value
        push_item(ACT_PAN,   16'd0,     3'd0, 24'h7FFFFF, 1'b1);  // empty table
        push_item(ACT_ADD,   16'd0,     3'd1, 24'h000000, 1'b0);
        push_item(ACT_PAN,   16'd100,   3'd5, 24'h800000, 1'b0);  // one speaker
        push_item(ACT_ADD,   16'h8000,  3'd0, 24'hFFFFFF, 1'b1);
        push_item(ACT_ADD,   16'h7FFF,  3'd7, 24'h123456, 1'b0);  // channel out of range
        push_item(ACT_ADD,   16'd5760,  3'd2, 24'h000001, 1'b0);  // equal to existing angle
        push_item(ACT_PAN,   16'd0,     3'd0, 24'h7FFFFF, 1'b0);
        push_item(ACT_PAN,   16'hFFFF,  3'd7, 24'h800000, 1'b1);  // wraps to 5759
        push_item(ACT_PAN,   16'd2000,  3'd3, 24'd12345,  1'b0);
        push_item(ACT_UNUSED, 16'hFFFF, 3'd7, 24'hFFFFFF, 1'b1);
        push_item(ACT_CLEAR, 16'd0,     3'd0, 24'h000000, 1'b0);
        push_item(ACT_ADD,   16'd1000,  3'd0, 24'h000000, 1'b0);
        push_item(ACT_ADD,   16'd1000,  3'd0, 24'h000000, 1'b0);  // both on one channel
        push_item(ACT_PAN,   16'd1000,  3'd0, 24'h400000, 1'b1);
        push_item(ACT_PAN,   16'd3000,  3'd0, 24'hC00000, 1'b0);
        for (j = 0; j < 6; j++)
            push_item(ACT_ADD, 16'(200 + j * 700), 3'(j + 1), 24'h0, 1'b0);
        push_item(ACT_ADD,   16'd5000,  3'd1, 24'h0,      1'b0);  // table full
        push_item(ACT_PAN,   16'd5000,  3'd1, 24'hFFFFFF, 1'b1);
        push_item(ACT_PAN,   16'hF000,  3'd6, 24'h7FFFFF, 1'b0);
        wait_drained();

        for (phase = 0; phase < 10; phase++) begin
            case (phase)
                0: setting = 4'd0;
                1: setting = 4'd15;
                2: setting = 4'd1;
                3: setting = 4'd8;
                default: setting = 4'($urandom_range(0, 15));
            endcase
            write_outputs(setting);
            tx_max = (phase % 4 == 3) ? 0 : 7;
            rx_max = (phase % 4 == 3) ? 0 : 7;
            if (phase == 2 || phase == 6) hold_cycles = 300;
            counted = 0;
            while (counted < 35) random_scene(counted);
            wait_drained();
        end

        if (channel_results_q.size() != 0)
            report_error($sformatf("%0d results never arrived", channel_results_q.size()));
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
